// ----- hdl/mxr_pkg.sv -----
// ----------------------------------------------------------------------------
// mxr_pkg
// Shared widths, constants and payload types of the quad-X motor mixer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mxr_pkg;

  // default number of fractional bits of the demand and motor words
  localparam int FRAC_BITS_DEF   = 14;
  // default depth of the queue between front and back
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int IN_W    = 16;  // demand word
  localparam int OUT_W   = 15;  // motor command word
  localparam int MIX_W   = 18;  // signed sum of three demands
  localparam int MAG_W   = 17;  // magnitude of a mix
  localparam int THR_W   = 15;  // clamped thrust, never above 32767
  localparam int SCALE_W = 16;  // fractional bits of the desaturation scale
  localparam int LANES   = 4;

  // motor lanes
  localparam int LANE_FR = 0;
  localparam int LANE_RR = 1;
  localparam int LANE_RL = 2;
  localparam int LANE_FL = 3;

  typedef struct packed {
    logic signed [IN_W-1:0] thrust;
    logic signed [IN_W-1:0] roll;
    logic signed [IN_W-1:0] pitch;
    logic signed [IN_W-1:0] yaw;
  } mxr_in_t;

  typedef struct packed {
    logic [OUT_W-1:0] motor_front_right;
    logic [OUT_W-1:0] motor_rear_right;
    logic [OUT_W-1:0] motor_rear_left;
    logic [OUT_W-1:0] motor_front_left;
  } mxr_out_t;

  // classified demand handed from front to back
  typedef struct packed {
    logic [THR_W-1:0]            thrust;
    logic [THR_W-1:0]            headroom;
    logic [MAG_W-1:0]            peak;
    logic                        scaling;
    logic [LANES-1:0][MIX_W-1:0] mix;
  } mxr_cls_t;

endpackage

// ----- hdl/mxr_front.sv -----
// ----------------------------------------------------------------------------
// mxr_front
// Takes a demand, clamps thrust, forms the four mixes, the peak magnitude and
// the headroom, and decides whether the mixes need scaling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mxr_front
  import mxr_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  mxr_in_t  in_data_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  output mxr_cls_t out_data_o,
  input  logic     out_ready_i
);

  localparam int CW = (FRAC_BITS + 2 > IN_W + 1) ? FRAC_BITS + 2 : IN_W + 1;
  localparam logic signed [CW-1:0] OneC = CW'(1) << FRAC_BITS;

  logic                          valid_q;
  mxr_cls_t                      data_q;
  mxr_cls_t                      data_d;
  logic signed [CW-1:0]          thr_ext;
  logic signed [CW-1:0]          thr_c;
  logic signed [CW-1:0]          up;
  logic signed [MIX_W-1:0]       roll_x;
  logic signed [MIX_W-1:0]       pitch_x;
  logic signed [MIX_W-1:0]       yaw_x;
  logic signed [MIX_W-1:0]       mix [LANES];
  logic [MAG_W-1:0]              mag [LANES];
  logic [MAG_W-1:0]              peak_a;
  logic [MAG_W-1:0]              peak_b;
  logic [MAG_W-1:0]              peak;
  logic [THR_W-1:0]              headroom;

  // thrust clamp and headroom
  always_comb begin
    thr_ext = {{(CW-IN_W){in_data_i.thrust[IN_W-1]}}, in_data_i.thrust};
    if (thr_ext < 0) begin
      thr_c = '0;
    end else if (thr_ext > OneC) begin
      thr_c = OneC;
    end else begin
      thr_c = thr_ext;
    end
    up       = OneC - thr_c;
    headroom = (up < thr_c) ? up[THR_W-1:0] : thr_c[THR_W-1:0];
  end

  // quad-X mixes
  always_comb begin
    roll_x       = {{(MIX_W-IN_W){in_data_i.roll[IN_W-1]}}, in_data_i.roll};
    pitch_x      = {{(MIX_W-IN_W){in_data_i.pitch[IN_W-1]}}, in_data_i.pitch};
    yaw_x        = {{(MIX_W-IN_W){in_data_i.yaw[IN_W-1]}}, in_data_i.yaw};
    mix[LANE_FR] = -roll_x - pitch_x + yaw_x;
    mix[LANE_RR] = -roll_x + pitch_x - yaw_x;
    mix[LANE_RL] =  roll_x + pitch_x + yaw_x;
    mix[LANE_FL] =  roll_x - pitch_x - yaw_x;
  end

  // magnitudes and peak through a two-level compare tree
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      mag[l] = mix[l][MIX_W-1] ? MAG_W'(-mix[l]) : MAG_W'(mix[l]);
    end
    peak_a = (mag[LANE_FR] > mag[LANE_RR]) ? mag[LANE_FR] : mag[LANE_RR];
    peak_b = (mag[LANE_RL] > mag[LANE_FL]) ? mag[LANE_RL] : mag[LANE_FL];
    peak   = (peak_a > peak_b) ? peak_a : peak_b;
  end

  // classified item
  always_comb begin
    data_d.thrust   = thr_c[THR_W-1:0];
    data_d.headroom = headroom;
    data_d.peak     = peak;
    data_d.scaling  = (peak != '0) && ({{(MAG_W-THR_W){1'b0}}, headroom} < peak);
    for (int l = 0; l < LANES; l++) begin
      data_d.mix[l] = mix[l];
    end
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  // input register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

// ----- hdl/mxr_queue.sv -----
// ----------------------------------------------------------------------------
// mxr_queue
// Short first-in first-out queue of classified items between front and back.
// DEPTH must be a power of two, at least two; the block itself does not check it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mxr_queue
  import mxr_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     wr_valid_i,
  input  mxr_cls_t wr_data_i,
  output logic     wr_ready_o,
  output logic     rd_valid_o,
  output mxr_cls_t rd_data_o,
  input  logic     rd_ready_i
);

  localparam int AW = $clog2(DEPTH);

  mxr_cls_t      entry_q [DEPTH];
  logic [AW-1:0] wptr_q, wptr_d;
  logic [AW-1:0] rptr_q, rptr_d;
  logic [AW:0]   count_q, count_d;
  logic          wr_en;
  logic          rd_en;

  assign wr_ready_o = (count_q != (AW+1)'(DEPTH));
  assign rd_valid_o = (count_q != '0);
  assign rd_data_o  = entry_q[rptr_q];
  assign wr_en      = wr_valid_i && wr_ready_o;
  assign rd_en      = rd_valid_o && rd_ready_i;

  // pointer and fill count update
  always_comb begin
    wptr_d  = wr_en ? wptr_q + AW'(1) : wptr_q;
    rptr_d  = rd_en ? rptr_q + AW'(1) : rptr_q;
    count_d = count_q;
    if (wr_en && !rd_en) begin
      count_d = count_q + (AW+1)'(1);
    end else if (rd_en && !wr_en) begin
      count_d = count_q - (AW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  // storage write
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      entry_q[wptr_q] <= wr_data_i;
    end
  end

endmodule

// ----- hdl/mxr_back.sv -----
// ----------------------------------------------------------------------------
// mxr_back
// Desaturation pipeline: one quotient bit of headroom/peak per stage, then
// the scaling multiply, then thrust add, clamp and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mxr_back
  import mxr_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  mxr_cls_t in_data_i,
  output logic     in_ready_o,
  output logic     empty,
  output mxr_out_t result_o,
  input  logic     pop
);

  localparam int DIV_STEPS = SCALE_W;
  localparam int PW = MAG_W + SCALE_W;
  localparam int SW = ((FRAC_BITS + 2 > MIX_W) ? FRAC_BITS + 2 : MIX_W) + 1;
  localparam logic signed [SW-1:0] OneS = SW'(1) << FRAC_BITS;

  logic                  adv;
  logic [DIV_STEPS:0]    vld_q;
  mxr_cls_t              cls_q [DIV_STEPS+1];
  logic [MAG_W-1:0]      rem_q [DIV_STEPS+1];
  logic [SCALE_W-1:0]    quo_q [DIV_STEPS+1];

  logic                  mul_vld_q;
  logic [THR_W-1:0]      mul_thr_q;
  logic signed [MIX_W-1:0] smix_q [LANES];
  logic signed [MIX_W-1:0] smix_d [LANES];
  logic [MAG_W-1:0]      mag [LANES];
  logic [PW-1:0]         prod [LANES];
  logic [MAG_W-1:0]      smag [LANES];

  logic signed [SW-1:0]  sum [LANES];
  logic [OUT_W-1:0]      motor_d [LANES];
  logic                  out_vld_q;
  mxr_out_t              out_q;

  // whole pipeline moves unless a result waits and is not taken
  assign adv        = !out_vld_q || pop;
  assign in_ready_o = adv;
  assign empty      = !out_vld_q;
  assign result_o   = out_q;

  // divider entry stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cls_q[0] <= in_data_i;
      rem_q[0] <= in_data_i.scaling ?
                  {{(MAG_W-THR_W){1'b0}}, in_data_i.headroom} : '0;
      quo_q[0] <= '0;
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic [MAG_W:0] trial;
    logic           ge;

    always_comb begin
      trial = {rem_q[k], 1'b0};
      ge    = (trial >= {1'b0, cls_q[k].peak});
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (adv) begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        cls_q[k+1] <= cls_q[k];
        rem_q[k+1] <= ge ? MAG_W'(trial - {1'b0, cls_q[k].peak}) : trial[MAG_W-1:0];
        quo_q[k+1] <= {quo_q[k][SCALE_W-2:0], ge};
      end
    end
  end

  // scaling multiply, sign restored on the truncated magnitude
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      mag[l]  = cls_q[DIV_STEPS].mix[l][MIX_W-1] ?
                MAG_W'(-$signed(cls_q[DIV_STEPS].mix[l])) :
                cls_q[DIV_STEPS].mix[l][MAG_W-1:0];
      prod[l] = PW'(mag[l]) * PW'(quo_q[DIV_STEPS]);
      smag[l] = prod[l][PW-1:SCALE_W];
      if (!cls_q[DIV_STEPS].scaling) begin
        smix_d[l] = $signed(cls_q[DIV_STEPS].mix[l]);
      end else if (cls_q[DIV_STEPS].mix[l][MIX_W-1]) begin
        smix_d[l] = -$signed({1'b0, smag[l]});
      end else begin
        smix_d[l] = $signed({1'b0, smag[l]});
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_vld_q <= 1'b0;
    end else if (adv) begin
      mul_vld_q <= vld_q[DIV_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mul_thr_q <= cls_q[DIV_STEPS].thrust;
      for (int l = 0; l < LANES; l++) begin
        smix_q[l] <= smix_d[l];
      end
    end
  end

  // thrust plus scaled mix, clamped to the motor range
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      sum[l] = $signed({{(SW-THR_W){1'b0}}, mul_thr_q})
             + $signed({{(SW-MIX_W){smix_q[l][MIX_W-1]}}, smix_q[l]});
      if (sum[l] < 0) begin
        motor_d[l] = '0;
      end else if (sum[l] > OneS) begin
        motor_d[l] = OneS[OUT_W-1:0];
      end else begin
        motor_d[l] = sum[l][OUT_W-1:0];
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= mul_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.motor_front_right <= motor_d[LANE_FR];
      out_q.motor_rear_right  <= motor_d[LANE_RR];
      out_q.motor_rear_left   <= motor_d[LANE_RL];
      out_q.motor_front_left  <= motor_d[LANE_FL];
    end
  end

endmodule

// ----- hdl/quad_x_motor_mixer.sv -----
// ----------------------------------------------------------------------------
// quad_x_motor_mixer: accepts one demand per cycle while full is low; a result
// passes the input register, queue, divider entry stage, 16 divider stages,
// multiply and result register; the divider forms one quotient bit per stage.
// Reset clears all valid state: empty high, full low, queue drained.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module quad_x_motor_mixer
  import mxr_pkg::*;
#(
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push,
  output logic     full,
  input  mxr_in_t  demand_i,
  output logic     empty,
  input  logic     pop,
  output mxr_out_t result_o
);

  logic     front_ready;
  logic     front_valid;
  mxr_cls_t front_data;
  logic     queue_ready;
  logic     queue_valid;
  mxr_cls_t queue_data;
  logic     back_ready;

  assign full = !front_ready;

  // front: clamp, mix and classify
  mxr_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (push),
    .in_data_i   (demand_i),
    .in_ready_o  (front_ready),
    .out_valid_o (front_valid),
    .out_data_o  (front_data),
    .out_ready_i (queue_ready)
  );

  // decoupling queue
  mxr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (front_valid),
    .wr_data_i  (front_data),
    .wr_ready_o (queue_ready),
    .rd_valid_o (queue_valid),
    .rd_data_o  (queue_data),
    .rd_ready_i (back_ready)
  );

  // back: desaturate and drive motors
  mxr_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (queue_valid),
    .in_data_i  (queue_data),
    .in_ready_o (back_ready),
    .empty      (empty),
    .result_o   (result_o),
    .pop        (pop)
  );

endmodule

// ----- hdl/mxr_checker.sv -----
// ----------------------------------------------------------------------------
// mxr_checker
// Port-level checks of the motor mixer, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mxr_checker
  import mxr_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     push,
  input logic     full,
  input logic     empty,
  input logic     pop,
  input mxr_out_t result_o
);

  localparam logic [31:0] OneI = 32'(1) << FRAC_BITS;

  // a reset edge leaves nothing to deliver and room to take a transfer
  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |=> empty && !full)
    else $error("mixer not idle after reset");

  // a waiting result holds until its transfer
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(result_o))
    else $error("waiting result changed or vanished");

  // every motor command stays within zero to full scale
  a_motor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (32'(result_o.motor_front_right) <= OneI) &&
               (32'(result_o.motor_rear_right) <= OneI) &&
               (32'(result_o.motor_rear_left) <= OneI) &&
               (32'(result_o.motor_front_left) <= OneI))
    else $error("motor command above full scale");

  // backpressure only builds up behind an input transfer
  a_full_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full) |-> $past(push))
    else $error("full rose without an input transfer");

endmodule

bind quad_x_motor_mixer mxr_checker #(
  .FRAC_BITS (FRAC_BITS)
) u_mxr_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .push     (push),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .result_o (result_o)
);

// ----- sim/quad_x_motor_mixer_tb.sv -----
// ----------------------------------------------------------------------------
// quad_x_motor_mixer_tb
// Pushes directed and random control demands into the mixer with random gaps,
// pops motor commands with random stalls and two long hold-offs, and compares
// every command with a local desaturation predictor, lane by lane.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module quad_x_motor_mixer_tb;
  import mxr_pkg::*;

  localparam int NUM_RANDOM  = 480;
  localparam int IDLE_LIMIT  = 3000;
  localparam int DRAIN_CYC   = 40;
  localparam int HOLD_CYC    = 300;
  localparam int MAX_REPORTS = 10;

  logic     clk_i;
  logic     rst_ni   = 1'b0;
  logic     push     = 1'b0;
  logic     pop      = 1'b0;
  mxr_in_t  demand_i = '0;
  logic     full;
  logic     empty;
  mxr_out_t result_o;

  mxr_in_t  demand_queue[$];
  mxr_out_t motor_queue[$];
  int       mismatch_count = 0;
  int       demands_sent   = 0;
  int       results_seen   = 0;
  int       gap_left       = 0;
  int       stall_left     = 0;
  int       hold_left      = 0;
  int       idle_cycles    = 0;

  quad_x_motor_mixer i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .full     (full),
    .demand_i (demand_i),
    .empty    (empty),
    .pop      (pop),
    .result_o (result_o)
  );

  // clock and reset
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // clamp a value to the unit range 0..1.0
  function automatic longint limit_unit(longint v);
    longint one_q;
    one_q = longint'(1) << FRAC_BITS_DEF;
    if (v < 0) return 0;
    if (v > one_q) return one_q;
    return v;
  endfunction

  // motor commands for one demand: mix, desaturate, add thrust, clamp
  function automatic mxr_out_t predict_motors(mxr_in_t d);
    longint   one_q, thr, rl, pt, yw, up, room, peak, scale, mag, m;
    longint   mx[LANES];
    bit       scaling;
    logic [OUT_W-1:0] lane[LANES];
    mxr_out_t r;
    one_q = longint'(1) << FRAC_BITS_DEF;
    thr   = limit_unit(longint'($signed(d.thrust)));
    rl    = longint'($signed(d.roll));
    pt    = longint'($signed(d.pitch));
    yw    = longint'($signed(d.yaw));
    mx[LANE_FR] = -rl - pt + yw;
    mx[LANE_RR] = -rl + pt - yw;
    mx[LANE_RL] =  rl + pt + yw;
    mx[LANE_FL] =  rl - pt - yw;
    peak = 0;
    for (int i = 0; i < LANES; i++) begin
      m = (mx[i] < 0) ? -mx[i] : mx[i];
      if (m > peak) peak = m;
    end
    up      = one_q - thr;
    room    = (up < thr) ? up : thr;
    scaling = (peak > 0) && (room < peak);
    scale   = scaling ? (room << SCALE_W) / peak : 0;
    for (int i = 0; i < LANES; i++) begin
      m = mx[i];
      if (scaling) begin
        mag = (((m < 0) ? -m : m) * scale) >>> SCALE_W;
        m   = (mx[i] < 0) ? -mag : mag;
      end
      m       = limit_unit(thr + m);
      lane[i] = m[OUT_W-1:0];
    end
    r.motor_front_right = lane[LANE_FR];
    r.motor_rear_right  = lane[LANE_RR];
    r.motor_rear_left   = lane[LANE_RL];
    r.motor_front_left  = lane[LANE_FL];
    return r;
  endfunction

  // idle length: mostly none, some short, a few long; none in steady stretches
  function automatic int pick_idle(bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  task automatic add_demand(int t, int r, int p, int y);
    mxr_in_t d;
    d.thrust = t[IN_W-1:0];
    d.roll   = r[IN_W-1:0];
    d.pitch  = p[IN_W-1:0];
    d.yaw    = y[IN_W-1:0];
    demand_queue.push_back(d);
  endtask

  // random demand: thrust mostly in the unit range, attitude demands small or fully random
  function automatic mxr_in_t random_demand();
    mxr_in_t d;
    int      sel;
    sel = $urandom_range(0, 9);
    d   = {$urandom(), $urandom()};
    if (sel >= 2 && sel <= 5) begin
      d.thrust = IN_W'($urandom_range(0, 16384));
      d.roll   = IN_W'($urandom_range(0, 8192) - 4096);
      d.pitch  = IN_W'($urandom_range(0, 8192) - 4096);
      d.yaw    = IN_W'($urandom_range(0, 8192) - 4096);
    end else if (sel >= 6 && sel <= 8) begin
      d.thrust = IN_W'($urandom_range(0, 16384));
    end else if (sel == 9) begin
      if ($urandom_range(0, 1) != 0) begin
        d.thrust = IN_W'($urandom_range(0, 64));
      end else begin
        d.thrust = IN_W'($urandom_range(16320, 16384));
      end
    end
    return d;
  endfunction

  // stimulus: directed corners, then random demands, then drain and verdict
  initial begin
    add_demand(8192, 0, 0, 0);                 // zero peak
    add_demand(0, 0, 0, 0);
    add_demand(8192, 100, -200, 300);          // enough headroom
    add_demand(8192, 2000, 1000, -500);
    add_demand(4000, 10000, -3000, 2500);      // scaled, mixed signs
    add_demand(12000, -7000, 6000, -5000);
    add_demand(1, 3, -5, 7);                   // headroom of one lsb
    add_demand(16383, -9, 4, 1);
    add_demand(16384, 5000, 5000, 5000);       // full thrust, no headroom
    add_demand(-32768, 1000, -1000, 500);      // negative thrust
    add_demand(-1, 32767, 32767, 32767);
    add_demand(32767, -32768, -32768, -32768); // excess thrust
    add_demand(20000, 300, 300, 300);
    add_demand(8192, 32767, 32767, 32767);     // largest demands
    add_demand(8192, -32768, -32768, -32768);
    add_demand(8192, -32768, 32767, -32768);
    add_demand(8192, 32767, -32768, 32767);
    add_demand(8191, -32768, -32768, 32767);
    add_demand(8192, 0, 0, -32768);
    add_demand(16384, 0, 0, 0);
    add_demand(10000, 4000, -4000, 0);         // scaled, peak above headroom
    add_demand(-21846, 21845, -21846, 21845);  // alternating bit patterns
    add_demand(21845, -21846, 21845, -21846);
    for (int i = 0; i < NUM_RANDOM; i++) demand_queue.push_back(random_demand());

    @(posedge clk_i);
    while (!rst_ni || demand_queue.size() > 0 || push || motor_queue.size() > 0)
      @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
    if (!empty) begin
      mismatch_count++;
      $display("error: result left in block with nothing expected");
    end
    if (mismatch_count == 0) begin
      $display("quad_x_motor_mixer_tb: PASS");
    end else begin
      $display("quad_x_motor_mixer_tb: FAIL");
    end
    $finish;
  end

  // driver: offers queued demands, predicts on each input transfer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push     <= 1'b0;
      demand_i <= '0;
      gap_left <= 0;
    end else begin
      if (push && !full) begin
        motor_queue.push_back(predict_motors(demand_i));
        void'(demand_queue.pop_front());
        demands_sent++;
        gap_left = pick_idle((demands_sent % 128) < 24);
      end
      if (!(push && full)) begin
        if (gap_left > 0) begin
          gap_left--;
          push <= 1'b0;
        end else if (demand_queue.size() > 0) begin
          push     <= 1'b1;
          demand_i <= demand_queue[0];
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // monitor: pops motor commands with stalls and checks each output transfer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop        <= 1'b0;
      stall_left <= 0;
      hold_left  <= 0;
    end else begin
      if (pop && !empty) begin
        if (motor_queue.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("error: unexpected result fr=%0d rr=%0d rl=%0d fl=%0d",
                     result_o.motor_front_right, result_o.motor_rear_right,
                     result_o.motor_rear_left, result_o.motor_front_left);
        end else begin
          if (result_o.motor_front_right !== motor_queue[0].motor_front_right ||
              result_o.motor_rear_right  !== motor_queue[0].motor_rear_right  ||
              result_o.motor_rear_left   !== motor_queue[0].motor_rear_left   ||
              result_o.motor_front_left  !== motor_queue[0].motor_front_left) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display("mismatch %0d: exp %0d %0d %0d %0d got %0d %0d %0d %0d",
                       results_seen,
                       motor_queue[0].motor_front_right, motor_queue[0].motor_rear_right,
                       motor_queue[0].motor_rear_left, motor_queue[0].motor_front_left,
                       result_o.motor_front_right, result_o.motor_rear_right,
                       result_o.motor_rear_left, result_o.motor_front_left);
          end
          void'(motor_queue.pop_front());
        end
        results_seen++;
        stall_left = pick_idle((results_seen % 128) >= 100);
        // long hold-off so the block fills up and stalls its input
        if (results_seen == 100 || results_seen == 350) hold_left = HOLD_CYC;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // watchdog: ends the run after too many cycles without any transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("error: timeout with %0d demands pending and %0d results expected",
                 demand_queue.size(), motor_queue.size());
        $display("quad_x_motor_mixer_tb: FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule
